// File: rtl/core/mtrd_pkg.sv
package mtrd_pkg;

   localparam int unsigned MtN = 624;
   localparam int unsigned MtM = 397;
   localparam int unsigned IdxW = 10;
   localparam logic [31:0] MtMatrix = 32'h9908B0DF;
   localparam logic [31:0] MtInitMult = 32'd1812433253;
   localparam logic [31:0] MtTemperB = 32'h9D2C5680;
   localparam logic [31:0] MtTemperC = 32'hEFC60000;
   localparam logic [31:0] SeedReset = 32'd5489;
   localparam int unsigned QueueDepth = 2;

   // configuration register indexes
   localparam logic [0:0] RegSeed = 1'b0;

   typedef enum logic [0:0] {
      FUNC_MOD   = 1'b0,
      FUNC_RANGE = 1'b1
   } func_type;

   // classified job passed from front to back
   typedef struct packed {
      logic        need_word;
      logic        raw;
      logic [31:0] modulus;
      logic [31:0] offset;
   } job_type;

   typedef enum logic [2:0] {
      ST_SEED,
      ST_IDLE,
      ST_TWIST_RD,
      ST_TWIST_WR,
      ST_FETCH,
      ST_FETCH_WAIT,
      ST_DIVIDE,
      ST_DONE
   } back_state_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & MtTemperB);
      y = y ^ ((y << 15) & MtTemperC);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// File: rtl/core/mtrd_if.sv
interface mtrd_req_if;
   import mtrd_pkg::*;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] limit;
   logic [31:0] first_bound;
   logic [31:0] second_bound;
   modport source (output valid, func, limit, first_bound, second_bound, input ready);
   modport sink (input valid, func, limit, first_bound, second_bound, output ready);
endinterface

interface mtrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   modport source (output valid, value, input ready);
   modport sink (input valid, value, output ready);
endinterface

// File: rtl/core/mtrd_front.sv
module mtrd_front
   import mtrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   mtrd_req_if.sink req,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job
);

   job_type     q_ff [QueueDepth];
   job_type     q_in;
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;
   logic        b_greater;
   logic [31:0] lo, hi, span;

   // classify the incoming word
   always_comb begin
      b_greater = $signed(req.second_bound) > $signed(req.first_bound);
      lo = b_greater ? req.first_bound : req.second_bound;
      hi = b_greater ? req.second_bound : req.first_bound;
      span = hi - lo;
      q_in = '0;
      if (func_type'(req.func) == FUNC_MOD) begin
         q_in.need_word = 1'b1;
         q_in.raw = (req.limit == 32'd0);
         q_in.modulus = req.limit;
      end else begin
         q_in.need_word = (span != 32'd0);
         q_in.raw = 1'b0;
         q_in.modulus = span;
         q_in.offset = (span == 32'd0) ? req.first_bound : lo;
      end
   end

   assign req.ready = (cnt_ff != 2'(QueueDepth));
   assign push = req.valid && req.ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_ready;
   assign job = q_ff[rp_ff];

   // small job queue
   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// File: rtl/core/mtrd_divider.sv
module mtrd_divider
   import mtrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] remainder
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff;
   logic [5:0]  cnt_ff;
   logic [32:0] trial;

   // restoring division, one bit a cycle
   always_comb begin
      trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      if (!trial[32]) rem_in = trial[31:0];
      else rem_in = {rem_ff[30:0], quo_ff[31]};
      quo_in = {quo_ff[30:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else if (start) cnt_ff <= 6'd32;
      else if (busy) cnt_ff <= cnt_ff - 6'd1;
   end

   assign busy = (cnt_ff != 6'd0);
   assign remainder = rem_ff;

endmodule

// File: rtl/core/mtrd_back.sv
module mtrd_back
   import mtrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        seed_wr,
   input  logic [31:0] seed,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job,
   mtrd_rsp_if.source  rsp
);

   logic [31:0] mem [MtN];
   back_state_type st_ff, st_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [IdxW-1:0] pos_ff, pos_in;
   logic [31:0] prev_ff, prev_in;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] rd_ff;
   job_type     job_ff;
   logic        job_ld;
   logic [31:0] out_ff, out_in;
   logic        ov_ff, ov_in;
   logic        we;
   logic [IdxW-1:0] waddr, raddr;
   logic [31:0] wdata;
   logic        div_start, div_busy;
   logic [31:0] div_rem, word;
   logic [IdxW-1:0] nxt_idx, far_idx;
   logic [31:0] mix, mixa, mul;

   function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] a,
                                                input logic [IdxW:0] b);
      logic [IdxW:0] s;
      s = {1'b0, a} + b;
      if (s >= (IdxW+1)'(MtN)) s = s - (IdxW+1)'(MtN);
      return s[IdxW-1:0];
   endfunction

   mtrd_divider u_div (
      .clock, .reset, .start(div_start), .dividend(word), .divisor(job_ff.modulus),
      .busy(div_busy), .remainder(div_rem)
   );

   assign word = temper(rd_ff);
   assign mul = MtInitMult * (prev_ff ^ (prev_ff >> 30));
   assign nxt_idx = wrap_add(idx_ff, (IdxW+1)'(1));
   assign far_idx = wrap_add(idx_ff, (IdxW+1)'(MtM));

   // state table memory, synchronous read
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      prev_in = prev_ff;
      cur_in = cur_ff;
      out_in = out_ff;
      ov_in = ov_ff;
      we = 1'b0;
      waddr = idx_ff;
      wdata = '0;
      raddr = idx_ff;
      job_ready = 1'b0;
      job_ld = 1'b0;
      div_start = 1'b0;
      mix = '0;
      mixa = '0;
      if (rsp.valid && rsp.ready) ov_in = 1'b0;
      case (st_ff)
         // seeding sweep: one entry a cycle
         ST_SEED: begin
            we = 1'b1;
            wdata = (idx_ff == '0) ? prev_ff : mul + 32'(idx_ff);
            prev_in = wdata;
            idx_in = idx_ff + IdxW'(1);
            if (idx_ff == IdxW'(MtN - 1)) begin
               st_in = ST_IDLE;
               pos_in = IdxW'(MtN);
            end
         end
         ST_IDLE: begin
            if (job_valid && !ov_ff) begin
               job_ready = 1'b1;
               job_ld = 1'b1;
               if (!job.need_word) begin
                  out_in = job.offset;
                  ov_in = 1'b1;
               end else if (pos_ff == IdxW'(MtN)) begin
                  st_in = ST_TWIST_RD;
                  idx_in = '0;
               end else st_in = ST_FETCH;
            end
         end
         // twist: three reads then one write per entry
         ST_TWIST_RD: begin
            raddr = idx_ff;
            st_in = ST_TWIST_WR;
            idx_in = idx_ff;
            pos_in = '0;
         end
         ST_TWIST_WR: begin
            // pos_ff used as micro step counter
            case (pos_ff[1:0])
               2'd0: begin raddr = nxt_idx; cur_in = rd_ff; pos_in = IdxW'(1); end
               2'd1: begin raddr = far_idx; prev_in = rd_ff; pos_in = IdxW'(2); end
               default: begin
                  mix = {cur_ff[31], prev_ff[30:0]};
                  mixa = (mix >> 1) ^ (mix[0] ? MtMatrix : 32'd0);
                  we = 1'b1;
                  wdata = rd_ff ^ mixa;
                  pos_in = '0;
                  if (idx_ff == IdxW'(MtN - 1)) begin
                     idx_in = '0;
                     st_in = ST_FETCH;
                  end else begin
                     idx_in = nxt_idx;
                     st_in = ST_TWIST_RD;
                  end
               end
            endcase
         end
         ST_FETCH: begin
            raddr = pos_ff;
            pos_in = pos_ff + IdxW'(1);
            st_in = ST_FETCH_WAIT;
         end
         ST_FETCH_WAIT: begin
            if (job_ff.raw) begin
               out_in = word;
               ov_in = 1'b1;
               st_in = ST_IDLE;
            end else begin
               div_start = 1'b1;
               st_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!div_busy) st_in = ST_DONE;
         end
         ST_DONE: begin
            if (!ov_ff) begin
               out_in = div_rem + job_ff.offset;
               ov_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (seed_wr) begin
         st_in = ST_SEED;
         idx_in = '0;
         prev_in = seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_SEED;
         idx_ff <= '0;
         pos_ff <= IdxW'(MtN);
         prev_ff <= SeedReset;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         idx_ff <= idx_in;
         pos_ff <= pos_in;
         prev_ff <= prev_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
      if (job_ld) job_ff <= job;
   end

   assign rsp.valid = ov_ff;
   assign rsp.value = out_ff;

endmodule

// File: rtl/core/mersenne_twister_ranged_draw_core.sv
// MT19937 ranged random draw core
// req channel: a word carries func, limit and two signed bounds; accepted on
// valid and ready. func 0 returns the tempered word mod limit (raw word when
// limit is 0); func 1 returns a draw in [lo, hi) between the bounds, or the
// bound itself when both are equal, consuming nothing.
// rsp channel: one value word per request, in request order.
// csr port: APB-style, register 0 at address 0 is the seed; writing it
// reseeds the table in a sweep over its 624 entries, during which no request
// is served. reset starts the same seeding sweep with seed 5489.
// a reduced draw takes a table fetch, the restoring divider and control steps;
// a raw draw takes only the fetch, and equal bounds need no fetch. the back
// end serves one draw at a time: it takes the next at the earliest in the
// cycle after the previous word leaves. a draw that needs a word once all 624
// are used (also the first after seeding) first regenerates the table, each
// entry by three reads and one write through the memory's single read port.
// a two-entry queue lets requests be accepted while the back end works;
// a stalled rsp holds its word and the back end waits before writing the next.
module mersenne_twister_ranged_draw_core
   import mtrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mtrd_req_if.sink    req,
   mtrd_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic        job_valid, job_ready;
   job_type     job;
   logic [31:0] seed_ff;
   logic        wr, seed_wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign seed_wr = wr && (csr_paddr == {RegSeed, 2'b00});
   assign csr_prdata = (csr_paddr == {RegSeed, 2'b00}) ? seed_ff : 32'd0;

   // seed register
   always_ff @(posedge clock) begin
      if (reset) seed_ff <= SeedReset;
      else if (seed_wr) seed_ff <= csr_pwdata;
   end

   mtrd_front u_front (
      .clock, .reset, .req, .job_valid, .job_ready, .job
   );

   mtrd_back u_back (
      .clock, .reset, .seed_wr, .seed(csr_pwdata), .job_valid, .job_ready, .job, .rsp
   );

endmodule

// File: verif/tb.sv
module tb;
   import mtrd_pkg::*;

   // scoreboard: own twister model and queue of pending draws
   class draw_board;
      logic [31:0] table_q [MtN];
      int unsigned pos;
      logic [31:0] pending_q [$];
      int          errors;

      function void seed_table(logic [31:0] s);
         logic [31:0] p;
         table_q[0] = s;
         for (int i = 1; i < MtN; i++) begin
            p = table_q[i-1];
            table_q[i] = 32'd1812433253 * (p ^ (p >> 30)) + i;
         end
         pos = MtN;
      endfunction

      function logic [31:0] next_word();
         logic [31:0] x, xa, y;
         if (pos >= MtN) begin
            for (int i = 0; i < MtN; i++) begin
               x = (table_q[i] & 32'h80000000) | (table_q[(i+1) % MtN] & 32'h7fffffff);
               xa = x >> 1;
               if (x[0]) xa = xa ^ 32'h9908B0DF;
               table_q[i] = table_q[(i + MtM) % MtN] ^ xa;
            end
            pos = 0;
         end
         y = table_q[pos];
         pos++;
         y = y ^ (y >> 11);
         y = y ^ ((y << 7) & 32'h9D2C5680);
         y = y ^ ((y << 15) & 32'hEFC60000);
         y = y ^ (y >> 18);
         return y;
      endfunction

      function void note_request(func_type f, logic [31:0] lim, logic [31:0] a,
                                 logic [31:0] b);
         logic [31:0] w, lo, hi, span;
         if (f == FUNC_MOD) begin
            w = next_word();
            pending_q.push_back(lim == 0 ? w : w % lim);
         end else begin
            if ($signed(b) > $signed(a)) begin
               lo = a; hi = b;
            end else begin
               lo = b; hi = a;
            end
            span = hi - lo;
            if (span == 0) pending_q.push_back(a);
            else begin
               w = next_word();
               pending_q.push_back((w % span) + lo);
            end
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_value(logic [31:0] v);
         logic [31:0] e;
         if (pending_q.size() == 0) begin
            report($sformatf("value %h with nothing pending", v));
            return;
         end
         e = pending_q.pop_front();
         if (v !== e) report($sformatf("value %h, want %h", v, e));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   mtrd_req_if req();
   mtrd_rsp_if rsp();

   draw_board board = new();
   int unsigned idle_cycles = 0;
   bit long_hold = 0;
   bit stim_done = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   mersenne_twister_ranged_draw_core u_dut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   initial begin
      req.valid = 0; req.func = 0; req.limit = 0;
      req.first_bound = 0; req.second_bound = 0;
      rsp.ready = 0;
   end

   // accepted words on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            board.note_request(func_type'(req.func), req.limit, req.first_bound,
                               req.second_bound);
         if (rsp.valid && rsp.ready) board.check_value(rsp.value);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog: its idle limit leaves room for table regeneration and seeding
   always @(posedge clock) begin
      if (idle_cycles > 20000) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // receiver stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset) rsp.ready <= 0;
      else if (long_hold) rsp.ready <= 0;
      else rsp.ready <= ($urandom_range(0, 3) != 0);
   end

   task automatic csr_write(logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= {RegSeed, 2'b00};
      csr_pwdata <= v; csr_penable <= 0;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      board.seed_table(v);
   endtask

   task automatic send_draw(func_type f, logic [31:0] lim, logic [31:0] a,
                            logic [31:0] b);
      req.valid <= 1; req.func <= f; req.limit <= lim;
      req.first_bound <= a; req.second_bound <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic pause_sender(int n);
      if (n > 0) begin
         req.valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_draws(int n);
      int burst;
      logic [31:0] a, lim;
      burst = 0;
      for (int i = 0; i < n; i++) begin
         if (burst == 0) begin
            pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
            burst = $urandom_range(1, 12);
         end
         burst--;
         a = $urandom;
         case ($urandom_range(0, 5))
            0: lim = 0;
            1: lim = $urandom_range(1, 16);
            default: lim = $urandom;
         endcase
         if ($urandom_range(0, 1))
            send_draw(FUNC_MOD, lim, $urandom, $urandom);
         else case ($urandom_range(0, 5))
            0: send_draw(FUNC_RANGE, $urandom, a, a);
            1: send_draw(FUNC_RANGE, $urandom, a, a + $urandom_range(1, 20));
            default: send_draw(FUNC_RANGE, $urandom, a, $urandom);
         endcase
      end
   endtask

   initial begin
      board.seed_table(SeedReset);
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed: field extremes, both functions, special cases
      send_draw(FUNC_MOD, 0, 0, 0);
      send_draw(FUNC_MOD, 1, 0, 0);
      send_draw(FUNC_MOD, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_draw(FUNC_MOD, 32'h80000000, 0, 0);
      send_draw(FUNC_MOD, 7, 32'h12345678, 0);
      send_draw(FUNC_RANGE, 0, 5, 5);
      send_draw(FUNC_RANGE, 32'hffffffff, 32'h80000000, 32'h80000000);
      send_draw(FUNC_RANGE, 0, 32'h80000000, 32'h7fffffff);
      send_draw(FUNC_RANGE, 0, 32'h7fffffff, 32'h80000000);
      send_draw(FUNC_RANGE, 0, 32'hffffffff, 0);
      send_draw(FUNC_RANGE, 0, 10, 3);
      send_draw(FUNC_RANGE, 0, 32'hfffffff6, 32'hfffffffb);
      send_draw(FUNC_RANGE, 0, 0, 1);
      drain();

      // seed extremes; a random seed follows the hold-off test
      csr_write(32'h0);
      random_draws(150);
      drain();
      csr_write(32'hffffffff);
      random_draws(150);

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            long_hold = 1;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         random_draws(40);
      join
      drain();
      csr_write($urandom);
      random_draws(300);
      drain();
      csr_write(SeedReset);
      random_draws(300);
      drain();
      if (board.errors == 0 && board.pending_q.size() == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end
endmodule

// File: files.f
rtl/core/mtrd_pkg.sv
rtl/core/mtrd_if.sv
rtl/core/mtrd_front.sv
rtl/core/mtrd_divider.sv
rtl/core/mtrd_back.sv
rtl/core/mersenne_twister_ranged_draw_core.sv
verif/tb.sv
